@@ rtl/core/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared widths, character codes and digit helper for the integer to ASCII
// radix converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    // Payload widths
    localparam int VALUE_W = 32;
    localparam int RADIX_W = 6;
    localparam int CH_W    = 7;

    // Default word width of a conversion
    localparam int VALUE_BITS_DEF = 32;

    // Radix limits
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] DEC_RADIX = 6'd10;

    // Character codes
    localparam logic [CH_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CH_W-1:0] CH_ALPHA = 7'h41;
    localparam logic [CH_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CH_W-1:0] CH_NUL   = 7'h00;

    // Digit value (0..35) to its ASCII character
    function automatic logic [CH_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CH_W-1:0] dx;
        dx = {1'b0, d};
        if (d < DEC_RADIX) begin
            digit_char = dx + CH_ZERO;
        end else begin
            digit_char = dx - {1'b0, DEC_RADIX} + CH_ALPHA;
        end
    endfunction

endpackage

@@ rtl/core/itoa_in_if.sv @@
// ----------------------------------------------------------------------------
// itoa_in_if
// Input channel: one conversion request per transaction.
// ----------------------------------------------------------------------------
interface itoa_in_if;
    logic                          valid;
    logic                          ready;
    logic [itoa_pkg::VALUE_W-1:0]  value;
    logic [itoa_pkg::RADIX_W-1:0]  radix;
    logic                          is_signed;
    logic                          add_terminator;

    modport source (output valid, value, radix, is_signed, add_terminator,
                    input ready);
    modport sink   (input valid, value, radix, is_signed, add_terminator,
                    output ready);
endinterface

@@ rtl/core/itoa_out_if.sv @@
// ----------------------------------------------------------------------------
// itoa_out_if
// Output channel: one ASCII character per transaction.
// ----------------------------------------------------------------------------
interface itoa_out_if;
    logic                       valid;
    logic                       ready;
    logic [itoa_pkg::CH_W-1:0]  ch;
    logic                       last;

    modport source (output valid, ch, last, input ready);
    modport sink   (input valid, ch, last, output ready);
endinterface

@@ rtl/core/integer_to_ascii_radix_core.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_core
// Converts one word to ASCII text in radix 2..36, most significant digit
// first, with optional minus sign (signed radix 10) and zero terminator.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                    | last beat
//  ---------+-----+--------------------------------------------+-------------
//  i_in     | in  | value, radix, is_signed, add_terminator    | n/a
//  o_out    | out | ch (ASCII), last                           | last = 1
//
//  Each digit comes from a bit-serial divide by the radix; read-back reads
//  each digit from the memory (S_RD) and loads it into the output register
//  (S_LD), with a state each for a minus sign and a terminator. A new
//  request is taken only after the last character is loaded, back in S_IDLE.
//  Reset is synchronous and active low; the digit memory needs no clearing.
//  Output stalls hold the read-back sequencer only.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_core #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    itoa_in_if.sink   i_in,
    itoa_out_if.source o_out
);

    localparam int AW = $clog2(VALUE_BITS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_MINUS = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_LD    = 3'd4;
    localparam logic [2:0] S_TERM  = 3'd5;

    logic [2:0]                      r_state;
    logic [VALUE_BITS-1:0]           r_mag;
    logic [itoa_pkg::RADIX_W-1:0]    r_radix;
    logic                            r_neg;
    logic                            r_term;
    logic [AW-1:0]                   r_idx;
    logic                            r_div_start;
    logic [itoa_pkg::CH_W-1:0]       r_q;

    logic                            r_o_valid;
    logic [itoa_pkg::CH_W-1:0]       r_o_ch;
    logic                            r_o_last;

    // Digit buffer, least significant digit at index 0
    logic [itoa_pkg::CH_W-1:0]       mem [VALUE_BITS];

    logic                            div_done;
    logic [VALUE_BITS-1:0]           div_quo;
    logic [itoa_pkg::RADIX_W-1:0]    div_rem;

    logic [VALUE_BITS+itoa_pkg::VALUE_W-1:0] value_ext;
    logic [VALUE_BITS-1:0]           word;
    logic [itoa_pkg::RADIX_W-1:0]    radix_c;
    logic                            neg_c;
    logic                            slot_free;

    // Request decode: word mask, radix clamp, sign handling
    always_comb begin
        value_ext = {{VALUE_BITS{1'b0}}, i_in.value};
        word      = value_ext[VALUE_BITS-1:0];
        if (i_in.radix < itoa_pkg::RADIX_MIN) begin
            radix_c = itoa_pkg::RADIX_MIN;
        end else if (i_in.radix > itoa_pkg::RADIX_MAX) begin
            radix_c = itoa_pkg::RADIX_MAX;
        end else begin
            radix_c = i_in.radix;
        end
        neg_c = i_in.is_signed && (radix_c == itoa_pkg::DEC_RADIX) &&
                word[VALUE_BITS-1];
    end

    assign slot_free  = !r_o_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    itoa_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_mag),
        .i_divisor  (r_radix),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // Digit memory write port
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && div_done) begin
            mem[r_idx] <= itoa_pkg::digit_char(div_rem);
        end
    end

    // Digit memory read port, registered data
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_q <= mem[r_idx];
        end
    end

    // Sequencer: divide loop, then reverse read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_idx       <= '0;
            r_neg       <= 1'b0;
            r_term      <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_mag       <= neg_c ? (~word + 1'b1) : word;
                        r_radix     <= radix_c;
                        r_neg       <= neg_c;
                        r_term      <= i_in.add_terminator;
                        r_idx       <= '0;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (div_quo != '0) begin
                            r_mag       <= div_quo;
                            r_idx       <= r_idx + 1'b1;
                            r_div_start <= 1'b1;
                        end else begin
                            r_state <= r_neg ? S_MINUS : S_RD;
                        end
                    end
                end
                S_MINUS: begin
                    if (slot_free) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_LD;
                end
                S_LD: begin
                    if (slot_free) begin
                        if (r_idx == '0) begin
                            r_state <= r_term ? S_TERM : S_IDLE;
                        end else begin
                            r_idx   <= r_idx - 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_TERM: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (slot_free) begin
            r_o_valid <= (r_state == S_MINUS) || (r_state == S_LD) ||
                         (r_state == S_TERM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            case (r_state)
                S_MINUS: begin
                    r_o_ch   <= itoa_pkg::CH_MINUS;
                    r_o_last <= 1'b0;
                end
                S_LD: begin
                    r_o_ch   <= r_q;
                    r_o_last <= (r_idx == '0) && !r_term;
                end
                S_TERM: begin
                    r_o_ch   <= itoa_pkg::CH_NUL;
                    r_o_last <= 1'b1;
                end
                default: begin
                    r_o_ch   <= r_o_ch;
                    r_o_last <= r_o_last;
                end
            endcase
        end
    end

    assign o_out.valid = r_o_valid;
    assign o_out.ch    = r_o_ch;
    assign o_out.last  = r_o_last;

endmodule

@@ rtl/core/itoa_div.sv @@
// ----------------------------------------------------------------------------
// itoa_div
// Bit-serial restoring divider: word by radix, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module itoa_div #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [VALUE_BITS-1:0]         i_dividend,
    input  logic [itoa_pkg::RADIX_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic [VALUE_BITS-1:0]         o_quo,
    output logic [itoa_pkg::RADIX_W-1:0]  o_rem
);

    localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [VALUE_BITS-1:0]         r_quo;
    logic [itoa_pkg::RADIX_W-1:0]  r_rem;
    logic [itoa_pkg::RADIX_W-1:0]  r_div;

    logic [itoa_pkg::RADIX_W:0]    shifted;
    logic [itoa_pkg::RADIX_W:0]    trial;
    logic                          ge;

    // One restoring step: bring down the next dividend bit
    always_comb begin
        shifted = {r_rem, r_quo[VALUE_BITS-1]};
        ge      = (shifted >= {1'b0, r_div});
        trial   = shifted - {1'b0, r_div};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder stays below the divisor, so it fits RADIX_W bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[VALUE_BITS-2:0], ge};
            r_rem <= ge ? trial[itoa_pkg::RADIX_W-1:0]
                        : shifted[itoa_pkg::RADIX_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

@@ tb/tb_integer_to_ascii_radix_core.sv @@
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_radix_core
// Self-checking bench for the integer to ASCII radix converter. Conversion
// requests are driven from a queue. Every accepted request is expanded into
// its expected character stream, and each character taken from the output
// channel is checked against the oldest entry of that stream. Directed
// corner cases come first, then random phases with source gaps, sink stalls
// and one long sink hold-off that backs up the request channel.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_radix_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_BITS    = itoa_pkg::VALUE_BITS_DEF;
    localparam int RST_CYCLES   = 12;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int PHASE_ITEMS  = 20;

    typedef struct packed {
        logic [itoa_pkg::VALUE_W-1:0] value;
        logic [itoa_pkg::RADIX_W-1:0] radix;
        logic                         is_signed;
        logic                         add_terminator;
    } t_conv_req;

    typedef struct packed {
        logic [itoa_pkg::CH_W-1:0] ch;
        logic                      last;
    } t_text_char;

    logic i_clk;
    logic i_rst_n;

    itoa_in_if  req_ch ();
    itoa_out_if text_ch ();

    integer_to_ascii_radix_core #(
        .VALUE_BITS (WORD_BITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (text_ch)
    );

    t_conv_req   pending_reqs [$];
    t_text_char  expected_text [$];
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          req_taken;
    bit          hold_req;
    int unsigned hold_left;
    int unsigned err_count;
    int unsigned cycle_count;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expected text of one conversion, most significant digit first
    function automatic void predict_text(input t_conv_req r);
        logic [63:0]               word_mask;
        logic [63:0]               word;
        logic [63:0]               base;
        logic [63:0]               mag;
        logic [63:0]               d;
        logic                      negative;
        logic [itoa_pkg::CH_W-1:0] digits [$];
        word_mask = (64'd1 << WORD_BITS) - 64'd1;
        word      = 64'(r.value) & word_mask;
        base      = 64'(r.radix);
        if (base < itoa_pkg::RADIX_MIN) base = 64'(itoa_pkg::RADIX_MIN);
        if (base > itoa_pkg::RADIX_MAX) base = 64'(itoa_pkg::RADIX_MAX);
        // minus sign only for signed decimal; other radixes print raw bits
        negative = r.is_signed && (base == itoa_pkg::DEC_RADIX) && word[WORD_BITS-1];
        mag      = negative ? ((~word + 64'd1) & word_mask) : word;
        do begin
            d   = mag % base;
            mag = mag / base;
            if (d < itoa_pkg::DEC_RADIX)
                digits.push_front(itoa_pkg::CH_ZERO + itoa_pkg::CH_W'(d));
            else
                digits.push_front(itoa_pkg::CH_ALPHA +
                                  itoa_pkg::CH_W'(d - itoa_pkg::DEC_RADIX));
        end while (mag != 64'd0);
        if (negative) expected_text.push_back('{ch: itoa_pkg::CH_MINUS, last: 1'b0});
        foreach (digits[i]) begin
            expected_text.push_back('{ch: digits[i],
                                      last: (i == digits.size() - 1) && !r.add_terminator});
        end
        if (r.add_terminator) expected_text.push_back('{ch: itoa_pkg::CH_NUL, last: 1'b1});
    endfunction

    // Random request, biased toward decimal, edge words and short numbers
    function automatic t_conv_req rand_req();
        t_conv_req r;
        case ($urandom_range(9))
            0:       r.radix = itoa_pkg::RADIX_W'($urandom_range(63));
            1, 2:    r.radix = itoa_pkg::DEC_RADIX;
            default: r.radix = itoa_pkg::RADIX_W'($urandom_range(itoa_pkg::RADIX_MAX,
                                                                 itoa_pkg::RADIX_MIN));
        endcase
        case ($urandom_range(4))
            0: r.value = $urandom_range(40);
            1: r.value = $urandom >> $urandom_range(31);
            2: r.value = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                                           : 32'h7FFF_FFFF - $urandom_range(3);
            default: r.value = $urandom;
        endcase
        r.is_signed      = 1'($urandom_range(1));
        r.add_terminator = 1'($urandom_range(1));
        return r;
    endfunction

    task automatic push_req(input logic [itoa_pkg::VALUE_W-1:0] value,
                            input logic [itoa_pkg::RADIX_W-1:0] radix,
                            input logic sgn, input logic term);
        pending_reqs.push_back('{value: value, radix: radix, is_signed: sgn,
                                 add_terminator: term});
    endtask

    // Block until every queued request has been taken by the DUT
    task automatic wait_sent();
        while (pending_reqs.size() != 0 || req_ch.valid) @(posedge i_clk);
    endtask

    task automatic run_random(input int n, input int unsigned sidle, input int unsigned rstall);
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        repeat (n) pending_reqs.push_back(rand_req());
        wait_sent();
    endtask

    // Request driver: moves on only after the current transaction completes
    always @(negedge i_clk) begin : drive_req
        t_conv_req nxt;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_taken) begin
            req_taken = 1'b0;
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_reqs.pop_front();
                req_ch.valid          <= 1'b1;
                req_ch.value          <= nxt.value;
                req_ch.radix          <= nxt.radix;
                req_ch.is_signed      <= nxt.is_signed;
                req_ch.add_terminator <= nxt.add_terminator;
            end else begin
                // idle: junk payload under a low valid
                req_ch.valid          <= 1'b0;
                req_ch.value          <= $urandom;
                req_ch.radix          <= itoa_pkg::RADIX_W'($urandom_range(63));
                req_ch.is_signed      <= 1'($urandom_range(1));
                req_ch.add_terminator <= 1'($urandom_range(1));
            end
        end
    end

    // Sink ready: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            text_ch.ready <= 1'b0;
        end else begin
            text_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on request transactions, check on character transactions
    always @(posedge i_clk) begin : check_text
        t_text_char want;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            predict_text('{value: req_ch.value, radix: req_ch.radix,
                           is_signed: req_ch.is_signed,
                           add_terminator: req_ch.add_terminator});
            req_taken = 1'b1;
        end
        if (i_rst_n && text_ch.valid && text_ch.ready) begin
            if (expected_text.size() == 0) begin
                err_count++;
                $display("%0t: unexpected char, expected none, got ch=%02h last=%0d",
                         $time, text_ch.ch, text_ch.last);
            end else begin
                want = expected_text.pop_front();
                if (text_ch.ch !== want.ch) begin
                    err_count++;
                    $display("%0t: ch mismatch, expected %02h, got %02h",
                             $time, want.ch, text_ch.ch);
                end
                if (text_ch.last !== want.last) begin
                    err_count++;
                    $display("%0t: last mismatch, expected %0d, got %0d",
                             $time, want.last, text_ch.last);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d chars still expected", $time, expected_text.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Test sequence
    initial begin
        i_rst_n               = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.value          = '0;
        req_ch.radix          = '0;
        req_ch.is_signed      = 1'b0;
        req_ch.add_terminator = 1'b0;
        text_ch.ready         = 1'b0;
        send_idle_pct         = 0;
        recv_stall_pct        = 0;
        req_taken             = 1'b0;
        hold_req              = 1'b0;
        hold_left             = 0;
        err_count             = 0;
        cycle_count           = 0;
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners: zero, full words, sign handling, radix clamping
        push_req(32'd0,          itoa_pkg::DEC_RADIX, 1'b0, 1'b0);
        push_req(32'd0,          itoa_pkg::RADIX_MIN, 1'b0, 1'b1);
        push_req(32'hFFFF_FFFF,  itoa_pkg::RADIX_MIN, 1'b0, 1'b1);
        push_req(32'h8000_0000,  itoa_pkg::DEC_RADIX, 1'b1, 1'b1);
        push_req(32'hFFFF_FFFF,  itoa_pkg::DEC_RADIX, 1'b1, 1'b0);
        push_req(32'hFFFF_FFFF,  6'd16,               1'b1, 1'b0);
        push_req(32'h7FFF_FFFF,  itoa_pkg::DEC_RADIX, 1'b1, 1'b1);
        push_req(32'hFFFF_FFFF,  itoa_pkg::RADIX_MAX, 1'b0, 1'b0);
        push_req(32'd35,         itoa_pkg::RADIX_MAX, 1'b1, 1'b1);
        push_req(32'd5,          6'd0,                1'b0, 1'b0);
        push_req(32'd6,          6'd1,                1'b1, 1'b1);
        push_req(32'd35,         6'd37,               1'b0, 1'b0);
        push_req(32'hFFFF_FFFF,  6'd63,               1'b1, 1'b1);
        push_req(32'o777,        6'd8,                1'b0, 1'b0);
        push_req(32'hFFFF_FFFF,  6'd3,                1'b0, 1'b1);
        push_req(32'hFFFF_FFFF,  itoa_pkg::DEC_RADIX, 1'b0, 1'b0);
        push_req(32'd12345,      itoa_pkg::DEC_RADIX, 1'b1, 1'b1);
        push_req(32'h8000_0000,  6'd16,               1'b1, 1'b1);
        push_req(32'd10,         6'd11,               1'b0, 1'b0);
        push_req(32'd0,          itoa_pkg::DEC_RADIX, 1'b1, 1'b1);
        push_req(32'd34,         6'd35,               1'b0, 1'b1);
        push_req(32'h5555_AAAA,  6'd32,               1'b1, 1'b0);
        wait_sent();

        // Random phases with different source and sink behavior
        run_random(PHASE_ITEMS, 0, 0);
        run_random(PHASE_ITEMS, 71, 0);
        run_random(PHASE_ITEMS, 0, 71);
        run_random(PHASE_ITEMS, 10, 10);

        // Backpressure: sink held off while the source keeps offering
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (PHASE_ITEMS) pending_reqs.push_back(rand_req());
        @(posedge i_clk);
        hold_req = 1'b1;
        wait_sent();

        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && expected_text.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/itoa_pkg.sv
rtl/core/itoa_in_if.sv
rtl/core/itoa_out_if.sv
rtl/core/itoa_div.sv
rtl/core/integer_to_ascii_radix_core.sv
tb/tb_integer_to_ascii_radix_core.sv
